[rtl/mt64_pkg.sv]
`default_nettype none
package mt64_pkg;

  localparam int unsigned STATE_WORDS = 312;
  localparam int unsigned MID_OFFSET  = 156;
  localparam int unsigned IDX_W       = $clog2(STATE_WORDS);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [63:0]      word_t;

  localparam idx_t  LAST_INDEX   = idx_t'(STATE_WORDS - 1);
  localparam word_t SEED_MULT    = 64'h5851f42d4c957f2d;
  localparam word_t TWIST_MATRIX = 64'hb5026f5aa96619e9;
  localparam word_t UPPER_MASK   = 64'hffffffff80000000;
  localparam word_t LOWER_MASK   = 64'h000000007fffffff;
  localparam word_t TEMPER_B     = 64'h5555555555555555;
  localparam word_t TEMPER_C     = 64'h71d67fffeda60000;
  localparam word_t TEMPER_D     = 64'hfff7eee000000000;

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic [1:0] {
    SEED_IDLE,
    SEED_MUL_LL,
    SEED_MUL_HL,
    SEED_MUL_LH
  } seed_state_t;

  typedef struct packed {
    logic  busy;
    logic  shift;
    word_t word;
  } seed_ctl_t;

  // New value of the oldest word, built from it, its successor and the word
  // half a state further on.
  function automatic word_t twist_word(input word_t head, input word_t next,
                                       input word_t far);
    word_t x;
    word_t a;
    x = (head & UPPER_MASK) | (next & LOWER_MASK);
    a = (x >> 1) ^ (x[0] ? TWIST_MATRIX : 64'd0);
    return far ^ a;
  endfunction

  function automatic word_t temper(input word_t y_in);
    word_t y;
    y = y_in;
    y = y ^ ((y >> 29) & TEMPER_B);
    y = y ^ ((y << 17) & TEMPER_C);
    y = y ^ ((y << 37) & TEMPER_D);
    y = y ^ (y >> 43);
    return y;
  endfunction

endpackage
`default_nettype wire

[rtl/mt64_in_if.sv]
`default_nettype none
interface mt64_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] seed_value;

  modport source (output valid, output op, output seed_value, input ready);
  modport sink   (input valid, input op, input seed_value, output ready);
endinterface
`default_nettype wire

[rtl/mt64_out_if.sv]
`default_nettype none
interface mt64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface
`default_nettype wire

[rtl/mt64_cell.sv]
`default_nettype none
// One word of the generator state; takes its neighbor's word on a shift.
module mt64_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift,
  input  wire mt64_pkg::word_t d,
  output mt64_pkg::word_t    q
);

  mt64_pkg::word_t word_r;
  mt64_pkg::word_t word_nxt;

  always_comb begin
    word_nxt = shift ? d : word_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign q = word_r;

endmodule
`default_nettype wire

[rtl/mt64_seeder.sv]
`default_nettype none
// Seeding sequencer: word k = SEED_MULT * (w ^ (w >> 62)) + k, built from
// three 32x32 partial products on one shared multiplier.
module mt64_seeder (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire mt64_pkg::word_t seed,
  input  wire mt64_pkg::word_t tail,
  output mt64_pkg::seed_ctl_t  ctl
);

  mt64_pkg::seed_state_t state_r;
  mt64_pkg::seed_state_t state_nxt;
  mt64_pkg::idx_t        k_r;
  mt64_pkg::idx_t        k_nxt;
  mt64_pkg::word_t       acc_r;
  mt64_pkg::word_t       acc_nxt;

  mt64_pkg::word_t xs;
  logic [31:0]     mul_a;
  logic [31:0]     mul_b;
  mt64_pkg::word_t prod;

  // The tail cell holds the previous word and stays put between shifts.
  assign xs   = tail ^ (tail >> 62);
  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mt64_pkg::SEED_IDLE:   if (start) state_nxt = mt64_pkg::SEED_MUL_LL;
      mt64_pkg::SEED_MUL_LL: state_nxt = mt64_pkg::SEED_MUL_HL;
      mt64_pkg::SEED_MUL_HL: state_nxt = mt64_pkg::SEED_MUL_LH;
      mt64_pkg::SEED_MUL_LH: begin
        state_nxt = (k_r == mt64_pkg::LAST_INDEX) ? mt64_pkg::SEED_IDLE
                                                  : mt64_pkg::SEED_MUL_LL;
      end
      default:               state_nxt = mt64_pkg::SEED_IDLE;
    endcase
  end

  always_comb begin
    ctl.busy  = (state_r != mt64_pkg::SEED_IDLE);
    ctl.shift = 1'b0;
    ctl.word  = seed;
    mul_a     = xs[31:0];
    mul_b     = mt64_pkg::SEED_MULT[31:0];
    acc_nxt   = acc_r;
    k_nxt     = k_r;
    unique case (state_r)
      mt64_pkg::SEED_IDLE: begin
        // The seed itself is word zero and goes straight into the row.
        if (start) begin
          ctl.shift = 1'b1;
          k_nxt     = mt64_pkg::idx_t'(1);
        end
      end
      mt64_pkg::SEED_MUL_LL: begin
        acc_nxt = prod;
      end
      mt64_pkg::SEED_MUL_HL: begin
        mul_a   = xs[63:32];
        acc_nxt = acc_r + {prod[31:0], 32'd0};
      end
      mt64_pkg::SEED_MUL_LH: begin
        mul_b     = mt64_pkg::SEED_MULT[63:32];
        ctl.shift = 1'b1;
        ctl.word  = acc_r + {prod[31:0], 32'd0} + 64'(k_r);
        k_nxt     = k_r + mt64_pkg::idx_t'(1);
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mt64_pkg::SEED_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule
`default_nettype wire

[rtl/mersenne_twister_64_generator_core.sv]
`default_nettype none
// Draw: the tempered word is in the output register in the cycle after the input
//   transfer; one draw per cycle is sustained while the result side keeps up.
// Reseed: the input is held off after the seed transfer until every later word
//   is built (three partial products per word on the shared 32x32 multiplier).
// Reset (synchronous, active low) clears every cell to zero and empties the
//   output register; draws before the first seed return zero.
module mersenne_twister_64_generator_core (
  input  wire logic clk,
  input  wire logic rst_n,
  mt64_in_if.sink   in_ch,
  mt64_out_if.source out_ch
);

  // The state lives in a row of cells. Cell 0 holds the oldest word, the
  // one due to be twisted next; cell 1 its successor; cell MID_OFFSET the
  // word half a state on. Every draw twists the oldest word, shifts the row
  // by one and enters the new word at the tail, so the row always holds the
  // words in the order a full in-place twist would visit them. This gives
  // the same sequence as twisting the whole state once every 312 draws, and
  // no read position needs to be kept.
  mt64_pkg::word_t     cell_q [mt64_pkg::STATE_WORDS];
  mt64_pkg::word_t     tail_d;
  logic                row_shift;
  mt64_pkg::word_t     twisted;

  mt64_pkg::seed_ctl_t seed_ctl;
  logic                in_xfer;
  logic                seed_xfer;
  logic                draw_xfer;

  logic                out_valid_r;
  logic                out_valid_nxt;
  mt64_pkg::word_t     out_data_r;

  // The output register frees up in the same cycle its word is taken, so a
  // new draw can be transferred while the previous result leaves.
  assign in_ch.ready = !seed_ctl.busy && (!out_valid_r || out_ch.ready);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign seed_xfer   = in_xfer && (in_ch.op == mt64_pkg::OP_SEED);
  assign draw_xfer   = in_xfer && (in_ch.op == mt64_pkg::OP_DRAW);

  mt64_seeder u_seeder (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seed_xfer),
    .seed  (in_ch.seed_value),
    .tail  (cell_q[mt64_pkg::STATE_WORDS-1]),
    .ctl   (seed_ctl)
  );

  assign twisted = mt64_pkg::twist_word(cell_q[0], cell_q[1],
                                        cell_q[mt64_pkg::MID_OFFSET]);

  // Draws and seeding never overlap: the input is held off while seeding.
  assign row_shift = draw_xfer || seed_ctl.shift;
  assign tail_d    = seed_ctl.shift ? seed_ctl.word : twisted;

  for (genvar i = 0; i < mt64_pkg::STATE_WORDS; i++) begin : g_cell
    mt64_pkg::word_t d;
    if (i == mt64_pkg::STATE_WORDS - 1) begin : g_tail
      assign d = tail_d;
    end else begin : g_link
      assign d = cell_q[i+1];
    end
    mt64_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (row_shift),
      .d     (d),
      .q     (cell_q[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (draw_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (draw_xfer) begin
      out_data_r <= mt64_pkg::temper(twisted);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.random_value = out_data_r;

endmodule
`default_nettype wire

[rtl/mt64_checker.sv]
`default_nettype none
module mt64_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_op,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_random_value
);

  logic seed_xfer;
  logic draw_xfer;

  assign seed_xfer = in_valid && in_ready && (in_op == mt64_pkg::OP_SEED);
  assign draw_xfer = in_valid && in_ready && (in_op == mt64_pkg::OP_DRAW);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_value))
    else $error("result changed or vanished while stalled");

  // Seeding holds the input off right after the seed transfer.
  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    seed_xfer |=> !in_ready)
    else $error("input accepted during seeding");

  // A seed transfer never produces a result.
  a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    seed_xfer |=> !$rose(out_valid))
    else $error("result appeared after a seed transfer");

  // Every draw transfer shows its result on the next cycle.
  a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
    draw_xfer |=> out_valid)
    else $error("draw transfer without a result");

endmodule

bind mersenne_twister_64_generator_core mt64_checker u_mt64_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_op            (in_ch.op),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_random_value (out_ch.random_value)
);
`default_nettype wire

[tb/tb_mersenne_twister_64_generator_core.sv]
`default_nettype none
module tb_mersenne_twister_64_generator_core;

  localparam int CLK_HALF     = 10;
  localparam int RANDOM_ITEMS = 1950;
  // Near the end of the stimulus both sides run without idling.
  localparam int QUIET_TAIL   = 200;
  // Longest time the block may stay busy with no result to show for it (a reseed).
  localparam int DRAIN_CYCLES = 1000;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct {
    logic            op;
    mt64_pkg::word_t seed;
  } gen_item_t;

  logic clk;
  logic rst_n;

  mt64_in_if  in_ch();
  mt64_out_if out_ch();

  mersenne_twister_64_generator_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gen_item_t       pending_items[$];
  mt64_pkg::word_t expected_words[$];
  mt64_pkg::word_t mt_words[mt64_pkg::STATE_WORDS];
  logic [8:0]      mt_pos;
  int              mismatch_count;
  int              cycle_count;
  int              in_gap;
  int              out_stall;
  mt64_pkg::word_t want_word;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report_mismatch(input string what, input mt64_pkg::word_t got,
                                 input mt64_pkg::word_t want);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
  endtask

  // Mirrors the generator state for one accepted transfer and records the
  // word a draw should return.
  task automatic advance_generator(input logic op, input mt64_pkg::word_t seed);
    mt64_pkg::word_t w;
    mt64_pkg::word_t x;
    mt64_pkg::word_t y;
    int              nxt;
    int              far;
    if (op == mt64_pkg::OP_SEED) begin
      mt_words[0] = seed;
      for (int k = 1; k < mt64_pkg::STATE_WORDS; k++) begin
        w = mt_words[k-1];
        mt_words[k] = mt64_pkg::SEED_MULT * (w ^ (w >> 62)) + mt64_pkg::word_t'(k);
      end
      mt_pos = 9'(mt64_pkg::STATE_WORDS);
    end else begin
      if (mt_pos >= mt64_pkg::STATE_WORDS) begin
        // Regenerate the whole table in place, oldest word first.
        for (int k = 0; k < mt64_pkg::STATE_WORDS; k++) begin
          nxt = (k + 1) % mt64_pkg::STATE_WORDS;
          far = (k + mt64_pkg::MID_OFFSET) % mt64_pkg::STATE_WORDS;
          x = (mt_words[k] & mt64_pkg::UPPER_MASK) | (mt_words[nxt] & mt64_pkg::LOWER_MASK);
          y = x >> 1;
          if (x[0]) y = y ^ mt64_pkg::TWIST_MATRIX;
          mt_words[k] = mt_words[far] ^ y;
        end
        mt_pos = '0;
      end
      y = mt_words[mt_pos];
      y = y ^ ((y >> 29) & mt64_pkg::TEMPER_B);
      y = y ^ ((y << 17) & mt64_pkg::TEMPER_C);
      y = y ^ ((y << 37) & mt64_pkg::TEMPER_D);
      y = y ^ (y >> 43);
      expected_words.push_back(y);
      mt_pos = mt_pos + 9'd1;
    end
  endtask

  task automatic queue_item(input logic op, input mt64_pkg::word_t seed);
    gen_item_t item;
    item.op   = op;
    item.seed = seed;
    pending_items.push_back(item);
  endtask

  // Draws carry random seed bits on the bus; the block must ignore them.
  task automatic queue_draws(input int count);
    for (int i = 0; i < count; i++) queue_item(mt64_pkg::OP_DRAW, {$urandom, $urandom});
  endtask

  function automatic mt64_pkg::word_t pick_seed();
    mt64_pkg::word_t s;
    case ($urandom_range(0, 7))
      0: s = '0;
      1: s = '1;
      2: s = mt64_pkg::word_t'(1) << $urandom_range(0, 63);
      default: s = {$urandom, $urandom};
    endcase
    return s;
  endfunction

  // Input side: presents the oldest pending item and holds it until transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_generator(in_ch.op, in_ch.seed_value);
        void'(pending_items.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Keep the offered item stable until the block takes it.
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 15) == 0) begin
        in_gap = $urandom_range(1, 16) - 1;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid      <= 1'b1;
        in_ch.op         <= pending_items[0].op;
        in_ch.seed_value <= pending_items[0].seed;
      end
    end
  end

  // Result side: checks every transfer against the oldest expected word.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected random_value", out_ch.random_value, '0);
        end else begin
          want_word = expected_words.pop_front();
          if (out_ch.random_value !== want_word) begin
            report_mismatch("random_value", out_ch.random_value, want_word);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 15) == 0) begin
        out_stall = $urandom_range(1, 16) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_mersenne_twister_64_generator_core failed");
      $finish;
    end
  end

  initial begin
    int made;
    int run;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = mt64_pkg::OP_DRAW;
    in_ch.seed_value = '0;
    out_ch.ready     = 1'b0;
    mismatch_count   = 0;
    cycle_count      = 0;
    in_gap           = 0;
    out_stall        = 0;
    foreach (mt_words[k]) mt_words[k] = '0;
    mt_pos = 9'(mt64_pkg::STATE_WORDS);

    // Draws before any seed come from the all-zero table and must read zero.
    queue_draws(3);
    queue_item(mt64_pkg::OP_SEED, '0);
    queue_draws(3);
    queue_item(mt64_pkg::OP_SEED, '1);
    queue_draws(3);
    queue_item(mt64_pkg::OP_SEED, 64'd1);
    queue_draws(2);
    queue_item(mt64_pkg::OP_SEED, 64'h8000_0000_0000_0000);
    queue_draws(2);
    // Back-to-back reseeds: only the second one may count.
    queue_item(mt64_pkg::OP_SEED, 64'h0123_4567_89ab_cdef);
    queue_item(mt64_pkg::OP_SEED, 64'd5489);
    queue_draws(3);

    // The first random run is long enough to wrap the read position twice.
    made = 0;
    queue_item(mt64_pkg::OP_SEED, pick_seed());
    queue_draws(640);
    made += 641;
    while (made < RANDOM_ITEMS) begin
      queue_item(mt64_pkg::OP_SEED, pick_seed());
      made++;
      if ($urandom_range(0, 5) == 0) begin
        queue_item(mt64_pkg::OP_SEED, pick_seed());
        made++;
      end
      run = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : $urandom_range(100, 700);
      if (run > RANDOM_ITEMS - made) run = RANDOM_ITEMS - made;
      queue_draws(run);
      made += run;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("tb_mersenne_twister_64_generator_core passed");
    end else begin
      $display("tb_mersenne_twister_64_generator_core failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
